// ===== design/huff_pkg.sv =====
// ----------------------------------------------------------------------------
// huff_pkg
// Shared types and constants of the Huffman encoder and bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

package huff_pkg;

  // input commands
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ENCODE = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;

  // kinds of work handed from front to back
  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam int TABLE_DEPTH = 256;
  localparam int WORD_BITS   = 16;
  localparam int LEN_W       = 5;
  localparam int SYM_W       = 8;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [LEN_W-1:0]     len;
    logic [WORD_BITS-1:0] word;
  } table_entry_t;

  typedef struct packed {
    logic         kind;
    table_entry_t code;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t data;
  } q_push_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic [OCNT_W-1:0] out_count;
  } back_status_t;

endpackage

`default_nettype wire

// ===== design/huff_front.sv =====
// ----------------------------------------------------------------------------
// huff_front
// Accepts items, keeps the code table and hands encode and flush work on.
// ----------------------------------------------------------------------------
`default_nettype none

module huff_front #(
  parameter int MAX_CODE_LEN  = 16,
  parameter int ALPHABET_SIZE = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic [1:0]                            cmd,
  input  wire logic [huff_pkg::SYM_W-1:0]            symbol,
  input  wire logic [huff_pkg::WORD_BITS-1:0]        code_word,
  input  wire logic [huff_pkg::LEN_W-1:0]            code_length,
  input  wire huff_pkg::q_status_t                   q_status,
  output huff_pkg::q_push_t                          q_push
);

  localparam int CAP = (MAX_CODE_LEN < huff_pkg::WORD_BITS) ? MAX_CODE_LEN
                                                            : huff_pkg::WORD_BITS;

  huff_pkg::table_entry_t code_mem [huff_pkg::TABLE_DEPTH];
  logic [huff_pkg::TABLE_DEPTH-1:0] entry_valid;

  logic                          accept;
  logic                          in_alpha;
  logic [huff_pkg::LEN_W-1:0]    len_sat;
  logic [huff_pkg::WORD_BITS-1:0] word_mask;
  huff_pkg::table_entry_t        load_entry;
  logic                          do_load;
  logic                          do_stage;
  logic [huff_pkg::QCNT_W:0]     credit;

  logic                          s1_valid;
  logic                          s1_kind;
  logic                          s1_hit;
  huff_pkg::table_entry_t        s1_entry;

  // reserve a queue slot for the item held in the lookup stage
  assign credit = {1'b0, q_status.count} + {{huff_pkg::QCNT_W{1'b0}}, s1_valid};
  assign full   = credit >= (huff_pkg::QCNT_W + 1)'(huff_pkg::QDEPTH);
  assign accept = push && !full;

  assign in_alpha  = {1'b0, symbol} < 9'(ALPHABET_SIZE);
  assign len_sat   = (code_length > huff_pkg::LEN_W'(CAP)) ? huff_pkg::LEN_W'(CAP)
                                                           : code_length;
  assign word_mask = huff_pkg::WORD_BITS'(~(17'h1ffff << len_sat));
  assign load_entry.len  = len_sat;
  assign load_entry.word = code_word & word_mask;

  assign do_load  = accept && (cmd == huff_pkg::CMD_LOAD) && in_alpha;
  assign do_stage = accept && (((cmd == huff_pkg::CMD_ENCODE) && in_alpha) ||
                               (cmd == huff_pkg::CMD_FLUSH));

  always_ff @(posedge clk) begin
    if (do_load) begin
      code_mem[symbol] <= load_entry;
    end
    s1_entry <= code_mem[symbol];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (do_load) begin
      entry_valid[symbol] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= do_stage;
    end
    s1_kind <= (cmd == huff_pkg::CMD_FLUSH) ? huff_pkg::KIND_FLUSH : huff_pkg::KIND_ENCODE;
    s1_hit  <= entry_valid[symbol];
  end

  // drop encodes of symbols with no code
  always_comb begin
    q_push.data.kind = s1_kind;
    q_push.data.code = s1_hit ? s1_entry : '0;
    q_push.valid     = s1_valid &&
                       ((s1_kind == huff_pkg::KIND_FLUSH) ||
                        (s1_hit && (s1_entry.len != '0)));
  end

endmodule

`default_nettype wire

// ===== design/huff_queue.sv =====
// ----------------------------------------------------------------------------
// huff_queue
// Short queue of work between the front and the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module huff_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire huff_pkg::q_push_t  q_push,
  input  wire logic               q_pop,
  output huff_pkg::q_entry_t      q_head,
  output huff_pkg::q_status_t     q_status
);

  huff_pkg::q_entry_t slots [huff_pkg::QDEPTH];
  logic [huff_pkg::QPTR_W-1:0] wr_ptr;
  logic [huff_pkg::QPTR_W-1:0] rd_ptr;
  logic [huff_pkg::QCNT_W-1:0] count;
  logic                        do_pop;

  assign do_pop          = q_pop && (count != '0);
  assign q_head          = slots[rd_ptr];
  assign q_status.count  = count;
  assign q_status.empty  = (count == '0);

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      slots[wr_ptr] <= q_push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({q_push.valid, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/huff_back.sv =====
// ----------------------------------------------------------------------------
// huff_back
// Bit packer: appends code bits, cuts whole bytes, pads the rest on flush and buffers the results.
// ----------------------------------------------------------------------------
`default_nettype none

module huff_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire huff_pkg::q_entry_t  q_head,
  input  wire huff_pkg::q_status_t q_status,
  output logic                     q_pop,
  input  wire logic                pop,
  output logic                     empty,
  output logic [7:0]               out_byte,
  output logic                     last,
  output huff_pkg::back_status_t   back_status
);

  localparam int ACC_W = 7 + huff_pkg::WORD_BITS;

  logic [6:0] pend_bits;
  logic [2:0] pend_count;
  logic [6:0] pend_bits_next;
  logic [2:0] pend_count_next;

  logic [7:0] obuf_byte [huff_pkg::OUT_DEPTH];
  logic       obuf_last [huff_pkg::OUT_DEPTH];
  logic [huff_pkg::OPTR_W-1:0] wr_ptr;
  logic [huff_pkg::OPTR_W-1:0] rd_ptr;
  logic [huff_pkg::OCNT_W-1:0] count;

  logic [ACC_W-1:0]          acc;
  logic [huff_pkg::LEN_W-1:0] total;
  logic [2:0]                rem;
  logic [3:0]                pad_sh;
  logic [1:0]                n_push;
  logic [7:0]                byte0;
  logic [7:0]                byte1;
  logic                      last0;
  logic                      do_out_pop;

  // take work only while two result slots are free
  assign q_pop      = !q_status.empty &&
                      (count <= huff_pkg::OCNT_W'(huff_pkg::OUT_DEPTH - 2));
  assign do_out_pop = pop && (count != '0);

  assign empty    = (count == '0);
  assign out_byte = obuf_byte[rd_ptr];
  assign last     = obuf_last[rd_ptr];
  assign back_status.out_count = count;

  always_comb begin
    acc    = (ACC_W'(pend_bits) << q_head.code.len) | ACC_W'(q_head.code.word);
    total  = huff_pkg::LEN_W'(pend_count) + q_head.code.len;
    pad_sh = 4'd8 - {1'b0, pend_count};
    byte0  = 8'(acc >> (total - huff_pkg::LEN_W'(8)));
    byte1  = 8'(acc >> (total - huff_pkg::LEN_W'(16)));
    last0  = 1'b1;
    n_push = 2'd0;
    rem    = pend_count;
    pend_bits_next  = pend_bits;
    pend_count_next = pend_count;
    if (q_head.kind == huff_pkg::KIND_FLUSH) begin
      byte0 = 8'({1'b0, pend_bits} << pad_sh);
      n_push = (pend_count != 3'd0) ? 2'd1 : 2'd0;
      pend_bits_next  = '0;
      pend_count_next = '0;
    end else begin
      priority if (total >= huff_pkg::LEN_W'(16)) begin
        n_push = 2'd2;
        last0  = 1'b0;
        rem    = 3'(total - huff_pkg::LEN_W'(16));
      end else if (total >= huff_pkg::LEN_W'(8)) begin
        n_push = 2'd1;
        rem    = 3'(total - huff_pkg::LEN_W'(8));
      end else begin
        n_push = 2'd0;
        rem    = 3'(total);
      end
      pend_bits_next  = 7'(acc) & ~(7'h7f << rem);
      pend_count_next = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (n_push != 2'd0)) begin
      obuf_byte[wr_ptr] <= byte0;
      obuf_last[wr_ptr] <= last0;
    end
    if (q_pop && (n_push == 2'd2)) begin
      obuf_byte[wr_ptr + 1'b1] <= byte1;
      obuf_last[wr_ptr + 1'b1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_count <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (q_pop) begin
        pend_bits  <= pend_bits_next;
        pend_count <= pend_count_next;
        wr_ptr     <= wr_ptr + huff_pkg::OPTR_W'(n_push);
      end
      if (do_out_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (q_pop ? huff_pkg::OCNT_W'(n_push) : '0)
                     - huff_pkg::OCNT_W'(do_out_pop);
    end
  end

endmodule

`default_nettype wire

// ===== design/huffman_encoder_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_encoder_bit_packer_unit
// Huffman encoder with bit packer: code table load, encode and flush.
// ----------------------------------------------------------------------------
// channel   direction  handshake         beat
// input     in         push / full       cmd, symbol, code_word, code_length
// result    out        empty / pop       out_byte, last
//
// An item enters each cycle while full is low; the first byte it causes
// shows on the result ports once it has passed the table read into the
// lookup stage, the work queue and the result buffer; the packer takes no
// work while fewer than two result slots are free. The packer emits up to
// two bytes per encode but the result port moves one byte a cycle, so a
// stream of two-byte encodes is held to the pace of the result port. rst
// clears the table valid bits, the bit accumulator and both queues. A stalled
// result side fills the result buffer, then the work queue, then raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_encoder_bit_packer_unit #(
  parameter int MAX_CODE_LEN  = 16,
  parameter int ALPHABET_SIZE = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  cmd,
  input  wire logic [7:0]  symbol,
  input  wire logic [15:0] code_word,
  input  wire logic [4:0]  code_length,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             last
);

  huff_pkg::q_push_t      q_push;
  huff_pkg::q_status_t    q_status;
  huff_pkg::q_entry_t     q_head;
  huff_pkg::back_status_t back_status;
  logic                   q_pop;

  huff_front #(
    .MAX_CODE_LEN  (MAX_CODE_LEN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .symbol      (symbol),
    .code_word   (code_word),
    .code_length (code_length),
    .q_status    (q_status),
    .q_push      (q_push)
  );

  huff_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .q_pop    (q_pop),
    .q_head   (q_head),
    .q_status (q_status)
  );

  huff_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_status    (q_status),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .last        (last),
    .back_status (back_status)
  );

`ifndef SYNTHESIS
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    q_push.valid |-> (q_status.count < huff_pkg::QCNT_W'(huff_pkg::QDEPTH)))
    else $error("work queue written while full");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.count <= huff_pkg::QCNT_W'(huff_pkg::QDEPTH))
    else $error("work queue count out of range");

  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    back_status.out_count <= huff_pkg::OCNT_W'(huff_pkg::OUT_DEPTH))
    else $error("result buffer count out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("not empty after reset");
`endif

endmodule

`default_nettype wire
